### sv/firc_pkg.sv
// ----------------------------------------------------------------------------
// firc_pkg
// Shared sizes, codes and arithmetic limits for the circular-line FIR filter.
// ----------------------------------------------------------------------------
package firc_pkg;

    localparam int TAPS     = 64;
    localparam int IDX_W    = $clog2(TAPS);
    localparam int DATA_W   = 16;
    localparam int PROD_W   = 2 * DATA_W;
    localparam int ACC_W    = PROD_W + $clog2(TAPS);
    localparam int Q_SHIFT  = 15;
    localparam int RND_W    = ACC_W - Q_SHIFT;
    localparam int OUT_MAX  = 32767;
    localparam int OUT_MIN  = -32768;

    localparam logic CMD_FILTER = 1'b0;
    localparam logic CMD_LOAD   = 1'b1;

endpackage

### sv/fir_filter_circular_unit.sv
// ----------------------------------------------------------------------------
// fir_filter_circular_unit
// Direct-form FIR filter over a circular sample line held in RAM.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall): cmd selects a sample (filter) or a
// coefficient load. A load writes coef_index's tap in the transfer cycle and
// gives no result; an index at or above TAPS is dropped.
// A sample is written at the head of the line in its transfer cycle, then
// one multiply-accumulate per tap runs from the oldest sample to the newest,
// one RAM read of each store per cycle.
// Output channel (out_valid / out_stall): one rounded, saturated Q1.15
// result per sample, held in an output register.
// Taps go through RAM read, product and accumulate; the sum is then rounded.
// The single MAC serves the tap loop, so no new item is taken until a
// sample's result is registered; a load completes in its transfer cycle.
// Reset: both RAMs are cleared, one address per cycle, over all TAPS
// addresses; the input is stalled during that pass.
// A stalled output holds its result; a finished sample waits for the output
// register to free before the next item is taken.
// ----------------------------------------------------------------------------
module fir_filter_circular_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic                               cmd,
    input  logic [5:0]                         coef_index,
    input  logic signed [firc_pkg::DATA_W-1:0] value,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic signed [firc_pkg::DATA_W-1:0] filtered_sample,
    output logic                               saturated
);

    import firc_pkg::*;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MAC,
        ST_DRAIN,
        ST_SAT
    } state_t;

    localparam logic [IDX_W-1:0]        LAST_IDX = IDX_W'(TAPS - 1);
    localparam logic signed [RND_W-1:0] RND_MAX  = RND_W'(OUT_MAX);
    localparam logic signed [RND_W-1:0] RND_MIN  = RND_W'(OUT_MIN);
    localparam logic signed [ACC_W-1:0] RND_BIAS = ACC_W'(1 << (Q_SHIFT - 1));

    state_t                    state_reg, state_next;
    logic [IDX_W-1:0]          cnt_reg, cnt_next;
    logic [IDX_W-1:0]          wp_reg, wp_next;
    logic                      rvld_reg, rvld_next;
    logic                      pvld_reg, pvld_next;
    logic                      out_valid_reg, out_valid_next;

    logic [IDX_W-1:0]          rptr_reg, rptr_next;
    logic signed [PROD_W-1:0]  prod_reg, prod_next;
    logic signed [ACC_W-1:0]   acc_reg, acc_next;
    logic signed [RND_W-1:0]   rnd_reg, rnd_next;
    logic signed [DATA_W-1:0]  filt_reg, filt_next;
    logic                      sat_reg, sat_next;

    logic                      accept;
    logic [IDX_W-1:0]          head;
    logic signed [ACC_W-1:0]   biased;

    logic                      s_we, c_we;
    logic [IDX_W-1:0]          s_waddr, c_waddr;
    logic [DATA_W-1:0]         s_wdata, c_wdata;
    logic [DATA_W-1:0]         s_rdata, c_rdata;

    assign in_stall        = (state_reg != ST_IDLE);
    assign accept          = in_valid && !in_stall;
    assign out_valid       = out_valid_reg;
    assign filtered_sample = filt_reg;
    assign saturated       = sat_reg;

    assign head   = (wp_reg == LAST_IDX) ? '0 : wp_reg + IDX_W'(1);
    assign biased = acc_reg + RND_BIAS;

    // RAM write ports: the clearing pass, else the accepted item
    always_comb
    begin
        s_we    = 1'b0;
        s_waddr = wp_reg;
        s_wdata = value;
        c_we    = 1'b0;
        c_waddr = IDX_W'(coef_index);
        c_wdata = value;
        if (state_reg == ST_CLEAR)
        begin
            s_we    = 1'b1;
            s_waddr = cnt_reg;
            s_wdata = '0;
            c_we    = 1'b1;
            c_waddr = cnt_reg;
            c_wdata = '0;
        end
        else if (accept)
        begin
            s_we = (cmd == CMD_FILTER);
            c_we = (cmd == CMD_LOAD) && (32'(coef_index) < 32'(TAPS));
        end
    end

    firc_ram #(
        .WIDTH (DATA_W),
        .DEPTH (TAPS)
    ) u_sample_ram (
        .clk   (clk),
        .we    (s_we),
        .waddr (s_waddr),
        .wdata (s_wdata),
        .raddr (rptr_reg),
        .rdata (s_rdata)
    );

    firc_ram #(
        .WIDTH (DATA_W),
        .DEPTH (TAPS)
    ) u_coef_ram (
        .clk   (clk),
        .we    (c_we),
        .waddr (c_waddr),
        .wdata (c_wdata),
        .raddr (cnt_reg),
        .rdata (c_rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        wp_next        = wp_reg;
        rptr_next      = rptr_reg;
        rvld_next      = 1'b0;
        pvld_next      = rvld_reg;
        prod_next      = $signed(s_rdata) * $signed(c_rdata);
        acc_next       = acc_reg;
        rnd_next       = rnd_reg;
        filt_next      = filt_reg;
        sat_next       = sat_reg;
        out_valid_next = out_valid_reg && out_stall;

        if (pvld_reg)
        begin
            acc_next = acc_reg + {{(ACC_W - PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                if (cnt_reg == LAST_IDX)
                begin
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + IDX_W'(1);
                end
            end
            ST_IDLE:
            begin
                if (accept && (cmd == CMD_FILTER))
                begin
                    wp_next    = head;
                    rptr_next  = head;
                    cnt_next   = '0;
                    acc_next   = '0;
                    state_next = ST_MAC;
                end
            end
            ST_MAC:
            begin
                rvld_next = 1'b1;
                rptr_next = (rptr_reg == LAST_IDX) ? '0 : rptr_reg + IDX_W'(1);
                if (cnt_reg == LAST_IDX)
                begin
                    cnt_next   = '0;
                    state_next = ST_DRAIN;
                end
                else
                begin
                    cnt_next = cnt_reg + IDX_W'(1);
                end
            end
            ST_DRAIN:
            begin
                // wait for the read and product stages to empty
                if (!rvld_reg && !pvld_reg)
                begin
                    rnd_next   = biased[ACC_W-1:Q_SHIFT];
                    state_next = ST_SAT;
                end
            end
            ST_SAT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    if (rnd_reg > RND_MAX)
                    begin
                        filt_next = DATA_W'(OUT_MAX);
                        sat_next  = 1'b1;
                    end
                    else if (rnd_reg < RND_MIN)
                    begin
                        filt_next = DATA_W'(OUT_MIN);
                        sat_next  = 1'b1;
                    end
                    else
                    begin
                        filt_next = rnd_reg[DATA_W-1:0];
                        sat_next  = 1'b0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            cnt_reg       <= '0;
            wp_reg        <= '0;
            rvld_reg      <= 1'b0;
            pvld_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            filt_reg      <= '0;
            sat_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            wp_reg        <= wp_next;
            rvld_reg      <= rvld_next;
            pvld_reg      <= pvld_next;
            out_valid_reg <= out_valid_next;
            filt_reg      <= filt_next;
            sat_reg       <= sat_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rptr_reg <= rptr_next;
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
        rnd_reg  <= rnd_next;
    end

endmodule

### sv/firc_ram.sv
// ----------------------------------------------------------------------------
// firc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module firc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
